// ===== design/tbm_pkg.sv =====
// Shared constants and helpers for the text block measure/layout unit.
// No dependencies.
package tbm_pkg;

    localparam int GLYPH_COUNT_DEF = 95;
    localparam int COUNT_BITS_DEF  = 16;

    // command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TEXT = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // mode flag bit positions
    localparam int FLAG_SHRINK = 0;
    localparam int FLAG_BR     = 1;
    localparam int FLAG_NL     = 2;
    localparam int FLAG_SEP    = 3;
    localparam int FLAG_PREM   = 4;

    // configuration register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_MAXL    = 3'd1;
    localparam logic [2:0] REG_BOXW    = 3'd2;
    localparam logic [2:0] REG_BOXH    = 3'd3;
    localparam logic [2:0] REG_ALIGNH  = 3'd4;
    localparam logic [2:0] REG_ALIGNV  = 3'd5;
    localparam logic [2:0] REG_PITCH   = 3'd6;
    localparam logic [2:0] REG_TALL    = 3'd7;

    // alignment codes
    localparam logic [1:0] ALIGN_START  = 2'd0;
    localparam logic [1:0] ALIGN_CENTER = 2'd1;
    localparam logic [1:0] ALIGN_END    = 2'd2;
    localparam logic [1:0] ALIGN_BAD    = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_BYTE   = 3'd1;
    localparam logic [2:0] ST_ZERO_LINES = 3'd2;
    localparam logic [2:0] ST_OVER_LIMIT = 3'd3;
    localparam logic [2:0] ST_ZERO_BOX   = 3'd4;
    localparam logic [2:0] ST_BAD_ALIGN  = 3'd5;

    // byte values
    localparam logic [7:0] BYTE_NL   = 8'h0A;
    localparam logic [7:0] GLYPH_LO  = 8'h20;
    localparam logic [7:0] GLYPH_HI  = 8'h7E;
    localparam logic [7:0] BR_LT     = 8'h3C;
    localparam logic [7:0] BR_B      = 8'h62;
    localparam logic [7:0] BR_R      = 8'h72;
    localparam logic [7:0] BR_GT     = 8'h3E;

    // table entries of the buffered tag bytes
    localparam logic [6:0] IDX_LT = 7'd28;
    localparam logic [6:0] IDX_B  = 7'd66;
    localparam logic [6:0] IDX_R  = 7'd82;

    localparam logic [16:0] SCALE_ONE = 17'h10000;

    // expected byte of the <br> tag after prog bytes matched
    function automatic logic [7:0] br_char(input logic [1:0] prog);
        logic [7:0] c;
        case (prog)
            2'd0:    c = BR_LT;
            2'd1:    c = BR_B;
            2'd2:    c = BR_R;
            default: c = BR_GT;
        endcase
        return c;
    endfunction

endpackage

// ===== design/tbm_width_mem.sv =====
// Glyph width table: single write port, registered read port.
// No dependencies.
module tbm_width_mem #(
    parameter int DEPTH = 95,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tbm_measure.sv =====
// Byte front end: tag matching, width table lookup and line accumulation.
// Depends on tbm_pkg and tbm_width_mem.
module tbm_measure #(
    parameter int GLYPH_COUNT = tbm_pkg::GLYPH_COUNT_DEF,
    parameter int COUNT_BITS  = tbm_pkg::COUNT_BITS_DEF,
    parameter int LW          = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [1:0]    cmd,
    input  logic [6:0]    entry_index,
    input  logic [7:0]    entry_width,
    input  logic [7:0]    text_byte,
    input  logic [15:0]   given_width,
    input  logic [15:0]   given_lines,
    input  logic [4:0]    mode_flags,
    output logic          end_busy,
    output logic          fin_valid,
    output logic [LW-1:0] fin_w,
    output logic [LW-1:0] fin_l,
    output logic          fin_bad
);

    localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int CB = COUNT_BITS;
    localparam int SW = COUNT_BITS + 3;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    // stage A: decode
    logic [1:0]    tag_reg, tag_next;
    logic          bad_reg, bad_next;
    logic [7:0]    w_lt_reg, w_b_reg, w_r_reg;
    logic [9:0]    flush_w;
    logic [7:0]    idx8;
    logic          a_valid, a_end, a_add, a_brk;
    logic [9:0]    a_flush;
    logic          mem_we, mem_re;
    logic [7:0]    mem_rdata;

    // stage B: accumulate
    logic          b_valid_reg, b_end_reg, b_add_reg, b_brk_reg;
    logic [9:0]    b_flush_reg;
    logic [15:0]   b_gw_reg, b_gl_reg;
    logic [CB-1:0] lw_reg, lw_next, widest_reg, widest_next, tally_reg, tally_next;
    logic [SW-1:0] sum;
    logic [CB-1:0] lwn, wmax;

    assign idx8   = text_byte - tbm_pkg::GLYPH_LO;
    assign mem_we = accept && (cmd == tbm_pkg::CMD_LOAD)
                    && (9'(entry_index) < 9'(GLYPH_COUNT));
    assign mem_re = accept && (cmd == tbm_pkg::CMD_TEXT);

    tbm_width_mem #(.DEPTH(GLYPH_COUNT), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(entry_index)),
        .wdata (entry_width),
        .re    (mem_re),
        .raddr (AW'(idx8)),
        .rdata (mem_rdata)
    );

    // shadow copies of the tag byte widths, so a flush needs no extra reads
    always_ff @(posedge aclk) begin
        if (mem_we && entry_index == tbm_pkg::IDX_LT) begin
            w_lt_reg <= entry_width;
        end
        if (mem_we && entry_index == tbm_pkg::IDX_B) begin
            w_b_reg <= entry_width;
        end
        if (mem_we && entry_index == tbm_pkg::IDX_R) begin
            w_r_reg <= entry_width;
        end
    end

    // tag bytes beyond the table have no width
    always_comb begin
        flush_w = 10'd0;
        if (tag_reg != 2'd0 && 9'(tbm_pkg::IDX_LT) < 9'(GLYPH_COUNT)) begin
            flush_w = flush_w + 10'(w_lt_reg);
        end
        if ((tag_reg == 2'd2 || tag_reg == 2'd3)
            && 9'(tbm_pkg::IDX_B) < 9'(GLYPH_COUNT)) begin
            flush_w = flush_w + 10'(w_b_reg);
        end
        if (tag_reg == 2'd3 && 9'(tbm_pkg::IDX_R) < 9'(GLYPH_COUNT)) begin
            flush_w = flush_w + 10'(w_r_reg);
        end
    end

    always_comb begin
        tag_next = tag_reg;
        bad_next = bad_reg;
        a_valid  = 1'b0;
        a_end    = 1'b0;
        a_add    = 1'b0;
        a_brk    = 1'b0;
        a_flush  = 10'd0;
        if (accept && cmd == tbm_pkg::CMD_TEXT) begin
            a_valid = 1'b1;
            if (tag_reg != 2'd0 && mode_flags[tbm_pkg::FLAG_BR]
                && text_byte == tbm_pkg::br_char(tag_reg)) begin
                if (tag_reg == 2'd3) begin
                    tag_next = 2'd0;
                    a_brk    = 1'b1;
                end else begin
                    tag_next = tag_reg + 2'd1;
                end
            end else begin
                a_flush  = flush_w;
                tag_next = 2'd0;
                if (mode_flags[tbm_pkg::FLAG_BR] && text_byte == tbm_pkg::BR_LT) begin
                    tag_next = 2'd1;
                end else if (mode_flags[tbm_pkg::FLAG_NL]
                             && text_byte == tbm_pkg::BYTE_NL) begin
                    a_brk = 1'b1;
                end else if (text_byte < tbm_pkg::GLYPH_LO
                             || text_byte > tbm_pkg::GLYPH_HI) begin
                    bad_next = 1'b1;
                end else begin
                    a_add = (9'(idx8) < 9'(GLYPH_COUNT));
                end
            end
        end else if (accept && cmd == tbm_pkg::CMD_END) begin
            a_valid  = 1'b1;
            a_end    = 1'b1;
            a_flush  = flush_w;
            tag_next = 2'd0;
        end
        // end transaction in stage B clears the sticky error; no new byte this cycle
        if (b_valid_reg && b_end_reg) begin
            bad_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg     <= 2'd0;
            bad_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            tag_reg     <= tag_next;
            bad_reg     <= bad_next;
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid) begin
            b_end_reg   <= a_end;
            b_add_reg   <= a_add;
            b_brk_reg   <= a_brk;
            b_flush_reg <= a_flush;
            b_gw_reg    <= given_width;
            b_gl_reg    <= given_lines;
        end
    end

    // saturating accumulate; all addends are nonnegative so one clamp suffices
    always_comb begin
        sum = SW'(lw_reg) + SW'(b_flush_reg) + SW'(b_add_reg ? mem_rdata : 8'd0);
        lwn = (sum > SW'(CMAX)) ? CMAX : sum[CB-1:0];
        wmax = (lwn > widest_reg) ? lwn : widest_reg;
        lw_next     = lw_reg;
        widest_next = widest_reg;
        tally_next  = tally_reg;
        if (b_valid_reg) begin
            if (b_end_reg) begin
                lw_next     = '0;
                widest_next = '0;
                tally_next  = CB'(1);
            end else if (b_brk_reg) begin
                lw_next     = '0;
                widest_next = wmax;
                if (tally_reg != CMAX) begin
                    tally_next = tally_reg + CB'(1);
                end
            end else begin
                lw_next = lwn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg     <= '0;
            widest_reg <= '0;
            tally_reg  <= CB'(1);
        end else begin
            lw_reg     <= lw_next;
            widest_reg <= widest_next;
            tally_reg  <= tally_next;
        end
    end

    assign end_busy  = b_valid_reg && b_end_reg;
    assign fin_valid = end_busy;
    assign fin_w     = mode_flags[tbm_pkg::FLAG_PREM] ? LW'(b_gw_reg) : LW'(wmax);
    assign fin_l     = mode_flags[tbm_pkg::FLAG_PREM] ? LW'(b_gl_reg) : LW'(tally_reg);
    assign fin_bad   = !mode_flags[tbm_pkg::FLAG_PREM] && bad_reg;

endmodule

// ===== design/tbm_divider.sv =====
// Restoring divider for the shrink scale, one quotient bit per cycle.
// Requires dividend < divisor. No dependencies.
module tbm_divider #(
    parameter int LW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [15:0]   dividend,
    input  logic [LW-1:0] divisor,
    output logic          done,
    output logic [15:0]   quotient
);

    logic          busy_reg, done_reg;
    logic [3:0]    cnt_reg;
    logic [LW-1:0] rem_reg;
    logic [15:0]   q_reg;
    logic [LW:0]   t;
    logic          ge;

    assign t  = {rem_reg, 1'b0};
    assign ge = (t >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 4'd15) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= LW'(dividend);
            cnt_reg <= 4'd0;
            q_reg   <= 16'd0;
        end else if (busy_reg) begin
            rem_reg <= ge ? LW'(t - {1'b0, divisor}) : t[LW-1:0];
            q_reg   <= {q_reg[14:0], ge};
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/tbm_layout.sv =====
// Layout sequencer: checks, shrink scale, rendered size, offsets, result register.
// Depends on tbm_pkg and tbm_divider.
module tbm_layout #(
    parameter int LW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fin_valid,
    input  logic [LW-1:0] fin_w,
    input  logic [LW-1:0] fin_l,
    input  logic          fin_bad,
    input  logic [4:0]    mode_flags,
    input  logic [15:0]   max_lines,
    input  logic [15:0]   box_w,
    input  logic [15:0]   box_h,
    input  logic [1:0]    align_horiz,
    input  logic [1:0]    align_vert,
    input  logic [15:0]   line_pitch,
    input  logic [15:0]   glyph_tall,
    output logic          idle,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic [15:0]   m_widest_line,
    output logic [15:0]   m_lines_total,
    output logic [16:0]   m_shrink_scale,
    output logic [23:0]   m_out_width,
    output logic [31:0]   m_out_height,
    output logic [24:0]   m_offset_x,
    output logic [32:0]   m_offset_y
);

    localparam int OWW = LW + 9;
    localparam int HW  = LW + 17;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_CHK  = 6'b000010,
        L_DIV  = 6'b000100,
        L_MULW = 6'b001000,
        L_MULH = 6'b010000,
        L_OUT  = 6'b100000
    } lay_state_t;

    lay_state_t state_reg, state_next;

    logic [LW-1:0]  w_reg, l_reg;
    logic           bad_reg;
    logic [2:0]     status_reg, status_chk;
    logic [16:0]    scale_reg;
    logic [OWW-1:0] ow_reg;
    logic [HW-1:0]  oh_raw_reg;
    logic           need_div, div_done, out_free, sep;
    logic [15:0]    div_q;
    logic [LW+16:0] prod_w;
    logic [LW+15:0] prod_h;
    logic [LW-1:0]  l_mul;
    logic [31:0]    oh_sat;
    logic signed [33:0] dx, dy, offx, offy;
    logic           m_valid_reg;

    always_comb begin
        if (bad_reg) begin
            status_chk = tbm_pkg::ST_BAD_BYTE;
        end else if (l_reg == '0) begin
            status_chk = tbm_pkg::ST_ZERO_LINES;
        end else if (max_lines != 16'd0 && l_reg > LW'(max_lines)) begin
            status_chk = tbm_pkg::ST_OVER_LIMIT;
        end else if (box_w == 16'd0 || box_h == 16'd0) begin
            status_chk = tbm_pkg::ST_ZERO_BOX;
        end else if (align_horiz == tbm_pkg::ALIGN_BAD
                     || align_vert == tbm_pkg::ALIGN_BAD) begin
            status_chk = tbm_pkg::ST_BAD_ALIGN;
        end else begin
            status_chk = tbm_pkg::ST_OK;
        end
    end

    assign need_div = (status_chk == tbm_pkg::ST_OK) && mode_flags[tbm_pkg::FLAG_SHRINK]
                      && (w_reg > LW'(box_w));
    assign out_free = !m_valid_reg || m_ready;
    assign sep      = mode_flags[tbm_pkg::FLAG_SEP];

    tbm_divider #(.LW(LW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == L_CHK && need_div),
        .dividend (box_w),
        .divisor  (w_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE: if (fin_valid) state_next = L_CHK;
            L_CHK: begin
                if (status_chk != tbm_pkg::ST_OK) begin
                    state_next = L_OUT;
                end else if (need_div) begin
                    state_next = L_DIV;
                end else begin
                    state_next = L_MULW;
                end
            end
            L_DIV:  if (div_done) state_next = L_MULW;
            L_MULW: state_next = L_MULH;
            L_MULH: state_next = L_OUT;
            L_OUT:  if (out_free) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= L_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == L_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign prod_w = w_reg * scale_reg;
    assign l_mul  = sep ? l_reg - LW'(1) : l_reg;
    assign prod_h = l_mul * line_pitch;
    assign oh_sat = (|oh_raw_reg[HW-1:32]) ? 32'hFFFF_FFFF : oh_raw_reg[31:0];

    // offsets; center is floor(diff/2), which the arithmetic shift gives
    always_comb begin
        dx = $signed({10'd0, box_w, 8'd0}) - $signed({2'd0, 32'(ow_reg)});
        dy = $signed({10'd0, box_h, 8'd0}) - $signed({2'd0, oh_sat});
        case (align_horiz)
            tbm_pkg::ALIGN_CENTER: offx = dx >>> 1;
            tbm_pkg::ALIGN_END:    offx = dx;
            default:               offx = '0;
        endcase
        case (align_vert)
            tbm_pkg::ALIGN_CENTER: offy = dy >>> 1;
            tbm_pkg::ALIGN_END:    offy = dy;
            default:               offy = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            L_IDLE: begin
                w_reg   <= fin_w;
                l_reg   <= fin_l;
                bad_reg <= fin_bad;
            end
            L_CHK: begin
                status_reg <= status_chk;
                scale_reg  <= tbm_pkg::SCALE_ONE;
            end
            L_DIV: if (div_done) scale_reg <= {1'b0, div_q};
            L_MULW: ow_reg <= prod_w[LW+16:8];
            L_MULH: oh_raw_reg <= HW'(prod_h) + (sep ? HW'(glyph_tall) : HW'(0));
            L_OUT: begin
                if (out_free) begin
                    m_status      <= status_reg;
                    m_widest_line <= w_reg[15:0];
                    m_lines_total <= l_reg[15:0];
                    if (status_reg == tbm_pkg::ST_OK) begin
                        m_shrink_scale <= scale_reg;
                        m_out_width    <= ow_reg[23:0];
                        m_out_height   <= oh_sat;
                        m_offset_x     <= offx[24:0];
                        m_offset_y     <= offy[32:0];
                    end else begin
                        m_shrink_scale <= '0;
                        m_out_width    <= '0;
                        m_out_height   <= '0;
                        m_offset_x     <= '0;
                        m_offset_y     <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign idle    = (state_reg == L_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== design/text_block_measure_layout_core.sv =====
// Text block measure/layout core. Load and text transactions: one per cycle while
// s_ready is high; the width table read is registered. End transaction: layout states
// check, divide (shrink only), multiply width, multiply height, output to the result
// register; no input is taken meanwhile. Reset (aresetn low, synchronous) clears
// control, measuring and config state; the width table is undefined until loaded.
module text_block_measure_layout_core #(
    parameter int GLYPH_COUNT = tbm_pkg::GLYPH_COUNT_DEF,
    parameter int COUNT_BITS  = tbm_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [6:0]  s_entry_index,
    input  logic [7:0]  s_entry_width,
    input  logic [7:0]  s_text_byte,
    input  logic [15:0] s_given_width,
    input  logic [15:0] s_given_lines,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_widest_line,
    output logic [15:0] m_lines_total,
    output logic [16:0] m_shrink_scale,
    output logic [23:0] m_out_width,
    output logic [31:0] m_out_height,
    output logic [24:0] m_offset_x,
    output logic [32:0] m_offset_y
);

    localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [4:0]  mode_reg;
    logic [15:0] maxl_reg, boxw_reg, boxh_reg, pitch_reg, tall_reg;
    logic [1:0]  alignh_reg, alignv_reg;

    logic          accept, end_busy, lay_idle, fin_valid, fin_bad;
    logic [LW-1:0] fin_w, fin_l;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            maxl_reg   <= '0;
            boxw_reg   <= '0;
            boxh_reg   <= '0;
            alignh_reg <= '0;
            alignv_reg <= '0;
            pitch_reg  <= '0;
            tall_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tbm_pkg::REG_MODE:   mode_reg   <= cfg_data[4:0];
                tbm_pkg::REG_MAXL:   maxl_reg   <= cfg_data;
                tbm_pkg::REG_BOXW:   boxw_reg   <= cfg_data;
                tbm_pkg::REG_BOXH:   boxh_reg   <= cfg_data;
                tbm_pkg::REG_ALIGNH: alignh_reg <= cfg_data[1:0];
                tbm_pkg::REG_ALIGNV: alignv_reg <= cfg_data[1:0];
                tbm_pkg::REG_PITCH:  pitch_reg  <= cfg_data;
                tbm_pkg::REG_TALL:   tall_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = lay_idle && !end_busy;
    assign accept  = s_valid && s_ready;

    tbm_measure #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .COUNT_BITS  (COUNT_BITS),
        .LW          (LW)
    ) u_measure (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (s_cmd),
        .entry_index (s_entry_index),
        .entry_width (s_entry_width),
        .text_byte   (s_text_byte),
        .given_width (s_given_width),
        .given_lines (s_given_lines),
        .mode_flags  (mode_reg),
        .end_busy    (end_busy),
        .fin_valid   (fin_valid),
        .fin_w       (fin_w),
        .fin_l       (fin_l),
        .fin_bad     (fin_bad)
    );

    tbm_layout #(.LW(LW)) u_layout (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fin_valid      (fin_valid),
        .fin_w          (fin_w),
        .fin_l          (fin_l),
        .fin_bad        (fin_bad),
        .mode_flags     (mode_reg),
        .max_lines      (maxl_reg),
        .box_w          (boxw_reg),
        .box_h          (boxh_reg),
        .align_horiz    (alignh_reg),
        .align_vert     (alignv_reg),
        .line_pitch     (pitch_reg),
        .glyph_tall     (tall_reg),
        .idle           (lay_idle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_widest_line  (m_widest_line),
        .m_lines_total  (m_lines_total),
        .m_shrink_scale (m_shrink_scale),
        .m_out_width    (m_out_width),
        .m_out_height   (m_out_height),
        .m_offset_x     (m_offset_x),
        .m_offset_y     (m_offset_y)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for text_block_measure_layout_core: directed table then random text.
// Depends on tbm_pkg and the core RTL.
module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [6:0]  idx;
        logic [7:0]  wid;
        logic [7:0]  tb;
        logic [15:0] gw;
        logic [15:0] gl;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] widest;
        logic [15:0] lines;
        logic [16:0] scale;
        logic [23:0] ow;
        logic [31:0] oh;
        logic [24:0] ox;
        logic [32:0] oy;
    } layout_t;

    // directed row: expected result typed in only when chk is set
    typedef struct {
        item_t   it;
        bit      chk;
        layout_t res;
    } row_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_index = tbm_pkg::REG_MODE;
    logic [15:0] cfg_data = 0;
    logic s_valid = 0, s_ready;
    logic [1:0] s_cmd = tbm_pkg::CMD_LOAD;
    logic [6:0] s_entry_index = 0;
    logic [7:0] s_entry_width = 0, s_text_byte = 0;
    logic [15:0] s_given_width = 0, s_given_lines = 0;
    logic m_valid, m_ready = 0;
    logic [2:0] m_status;
    logic [15:0] m_widest_line, m_lines_total;
    logic [16:0] m_shrink_scale;
    logic [23:0] m_out_width;
    logic [31:0] m_out_height;
    logic [24:0] m_offset_x;
    logic [32:0] m_offset_y;

    text_block_measure_layout_core dut (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic [4:0]  p_mode;
    logic [15:0] p_maxl, p_boxw, p_boxh, p_pitch, p_tall;
    logic [1:0]  p_ah, p_av;
    logic [7:0]  p_wtab [0:94];
    logic [15:0] p_lw, p_widest, p_tally;
    int          p_prog;
    bit          p_bad;

    layout_t layout_q[$];
    int errors = 0;
    int idle_pct = 18;
    int quiet = 0;
    bit wd_fail = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [7:0] tag_byte(input int k);
        case (k)
            0: return tbm_pkg::BR_LT;
            1: return tbm_pkg::BR_B;
            2: return tbm_pkg::BR_R;
            default: return tbm_pkg::BR_GT;
        endcase
    endfunction

    function automatic void put_glyph(input logic [7:0] b);
        int s;
        if (b < tbm_pkg::GLYPH_LO || b > tbm_pkg::GLYPH_HI) begin
            p_bad = 1;
            return;
        end
        s = p_lw + p_wtab[b - tbm_pkg::GLYPH_LO];
        p_lw = (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void new_line();
        if (p_lw > p_widest) p_widest = p_lw;
        p_lw = 0;
        if (p_tally != 16'hFFFF) p_tally++;
    endfunction

    function automatic void spill_tag();
        for (int i = 0; i < p_prog; i++) put_glyph(tag_byte(i));
        p_prog = 0;
    endfunction

    function automatic void clear_meas();
        p_lw = 0; p_widest = 0; p_tally = 1; p_prog = 0; p_bad = 0;
    endfunction

    function automatic longint half_floor(input longint d);
        return (d >= 0) ? d / 2 : -((-d + 1) / 2);
    endfunction

    function automatic longint place(input logic [1:0] sel, input longint d);
        if (sel == tbm_pkg::ALIGN_CENTER) return half_floor(d);
        if (sel == tbm_pkg::ALIGN_END) return d;
        return 0;
    endfunction

    // returns 1 when a layout result is produced
    function automatic bit measure_step(input item_t it, output layout_t r);
        longint w, l, sc, ow, oh;
        logic [2:0] st;
        bit br, nl;
        r = '0;
        br = p_mode[tbm_pkg::FLAG_BR];
        nl = p_mode[tbm_pkg::FLAG_NL];
        case (it.cmd)
            tbm_pkg::CMD_LOAD: begin
                if (it.idx < 95) p_wtab[it.idx] = it.wid;
                return 0;
            end
            tbm_pkg::CMD_TEXT: begin
                if (p_prog != 0) begin
                    if (br && it.tb == tag_byte(p_prog)) begin
                        if (p_prog == 3) begin
                            p_prog = 0;
                            new_line();
                        end else p_prog++;
                        return 0;
                    end
                    spill_tag();
                end
                if (br && it.tb == tbm_pkg::BR_LT) p_prog = 1;
                else if (nl && it.tb == tbm_pkg::BYTE_NL) new_line();
                else put_glyph(it.tb);
                return 0;
            end
            tbm_pkg::CMD_END: begin
                spill_tag();
                if (p_lw > p_widest) p_widest = p_lw;
                st = tbm_pkg::ST_OK;
                w = p_widest;
                l = p_tally;
                if (p_mode[tbm_pkg::FLAG_PREM]) begin
                    w = it.gw;
                    l = it.gl;
                end else if (p_bad) st = tbm_pkg::ST_BAD_BYTE;
                r.widest = w[15:0];
                r.lines = l[15:0];
                if (st == tbm_pkg::ST_OK && l == 0) st = tbm_pkg::ST_ZERO_LINES;
                if (st == tbm_pkg::ST_OK && p_maxl != 0 && l > p_maxl)
                    st = tbm_pkg::ST_OVER_LIMIT;
                if (st == tbm_pkg::ST_OK && (p_boxw == 0 || p_boxh == 0))
                    st = tbm_pkg::ST_ZERO_BOX;
                if (st == tbm_pkg::ST_OK && (p_ah == tbm_pkg::ALIGN_BAD
                                             || p_av == tbm_pkg::ALIGN_BAD))
                    st = tbm_pkg::ST_BAD_ALIGN;
                if (st == tbm_pkg::ST_OK) begin
                    sc = 65536;
                    if (p_mode[tbm_pkg::FLAG_SHRINK] && w > p_boxw)
                        sc = (longint'(p_boxw) << 16) / w;
                    ow = (w * sc) >> 8;
                    if (p_mode[tbm_pkg::FLAG_SEP]) oh = (l - 1) * p_pitch + p_tall;
                    else oh = l * p_pitch;
                    if (oh > 64'hFFFF_FFFF) oh = 64'hFFFF_FFFF;
                    r.scale = sc[16:0];
                    r.ow = ow[23:0];
                    r.oh = oh[31:0];
                    r.ox = 25'(place(p_ah, longint'(p_boxw) * 256 - ow));
                    r.oy = 33'(place(p_av, longint'(p_boxh) * 256 - oh));
                end
                r.status = st;
                clear_meas();
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        case (idx)
            tbm_pkg::REG_MODE:   p_mode = val[4:0];
            tbm_pkg::REG_MAXL:   p_maxl = val;
            tbm_pkg::REG_BOXW:   p_boxw = val;
            tbm_pkg::REG_BOXH:   p_boxh = val;
            tbm_pkg::REG_ALIGNH: p_ah = val[1:0];
            tbm_pkg::REG_ALIGNV: p_av = val[1:0];
            tbm_pkg::REG_PITCH:  p_pitch = val;
            default:             p_tall = val;
        endcase
    endtask

    task automatic settle();
        s_valid <= 0;
        while (layout_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic configure(input logic [4:0] mode, input logic [15:0] maxl, bw, bh,
                             input logic [1:0] ah, av, input logic [15:0] pitch, tall);
        settle();
        cfg_write(tbm_pkg::REG_MODE, 16'(mode)); cfg_write(tbm_pkg::REG_MAXL, maxl);
        cfg_write(tbm_pkg::REG_BOXW, bw); cfg_write(tbm_pkg::REG_BOXH, bh);
        cfg_write(tbm_pkg::REG_ALIGNH, 16'(ah)); cfg_write(tbm_pkg::REG_ALIGNV, 16'(av));
        cfg_write(tbm_pkg::REG_PITCH, pitch); cfg_write(tbm_pkg::REG_TALL, tall);
        cfg_wr_en <= 0;
    endtask

    // valid stays up between back-to-back transactions; it drops only while idling
    task automatic send(input item_t it);
        layout_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_cmd <= it.cmd; s_entry_index <= it.idx; s_entry_width <= it.wid;
        s_text_byte <= it.tb; s_given_width <= it.gw; s_given_lines <= it.gl;
        do @(posedge aclk); while (!s_ready);
        if (measure_step(it, r)) layout_q.push_back(r);
    endtask

    function automatic item_t mk(input logic [1:0] c, input logic [7:0] b,
                                 input logic [15:0] gw = 0, input logic [15:0] gl = 0);
        item_t it;
        it = '0;
        it.cmd = c; it.tb = b; it.gw = gw; it.gl = gl;
        it.idx = 7'($urandom); it.wid = 8'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] rand_text();
        int k;
        k = $urandom_range(99);
        if (k < 25) return tag_byte($urandom_range(3));
        if (k < 35) return tbm_pkg::BYTE_NL;
        if (k < 40) return 8'($urandom);
        return 8'($urandom_range(tbm_pkg::GLYPH_HI, tbm_pkg::GLYPH_LO));
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= idle_pct);
            if (m_valid && m_ready) begin
                if (layout_q.size() == 0) report("unexpected result", m_status, 0);
                else begin
                    layout_t e;
                    e = layout_q.pop_front();
                    if (m_status !== e.status) report("status", m_status, e.status);
                    if (m_widest_line !== e.widest) report("widest_line", m_widest_line, e.widest);
                    if (m_lines_total !== e.lines) report("lines_total", m_lines_total, e.lines);
                    if (m_shrink_scale !== e.scale) report("shrink_scale", m_shrink_scale, e.scale);
                    if (m_out_width !== e.ow) report("out_width", m_out_width, e.ow);
                    if (m_out_height !== e.oh) report("out_height", m_out_height, e.oh);
                    if (m_offset_x !== e.ox) report("offset_x", m_offset_x, e.ox);
                    if (m_offset_y !== e.oy) report("offset_y", m_offset_y, e.oy);
                end
            end
        end
    end

    // watchdog on transaction activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || cfg_wr_en) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        row_t rw;
        item_t it;
        layout_t r;
        string txt;
        p_mode = 0; p_maxl = 0; p_boxw = 0; p_boxh = 0; p_ah = 0; p_av = 0;
        p_pitch = 0; p_tall = 0;
        clear_meas();
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // full table load, widths random but with extremes at the ends
        for (int i = 0; i < 95; i++) begin
            it = mk(tbm_pkg::CMD_LOAD, 0);
            it.idx = 7'(i);
            it.wid = (i == 0) ? 8'd0 : (i == 94) ? 8'hFF : 8'($urandom);
            send(it);
        end
        it = mk(tbm_pkg::CMD_LOAD, 0); it.idx = 7'h7F; send(it);   // out of range load ignored
        it = mk(tbm_pkg::CMD_LOAD, 0); it.idx = 7'd95; send(it);

        // directed table under reset registers: errors readable at a glance
        rw.it = mk(tbm_pkg::CMD_END, 0); rw.chk = 1;
        rw.res = '{tbm_pkg::ST_ZERO_BOX, 16'd0, 16'd1, 17'd0, 24'd0, 32'd0, 25'd0, 33'd0};
        rows.push_back(rw);
        rw.it = mk(tbm_pkg::CMD_TEXT, 8'h00); rw.chk = 0; rows.push_back(rw);
        rw.it = mk(tbm_pkg::CMD_TEXT, 8'hFF); rows.push_back(rw);
        rw.it = mk(tbm_pkg::CMD_END, 0); rw.chk = 1;
        rw.res = '{tbm_pkg::ST_BAD_BYTE, 16'd0, 16'd1, 17'd0, 24'd0, 32'd0, 25'd0, 33'd0};
        rows.push_back(rw);
        foreach (rows[i]) begin
            send(rows[i].it);
            if (rows[i].chk) begin
                r = layout_q[$];
                if (r !== rows[i].res) report("directed row", i, 0);
            end
        end

        // tag, newline, partial tag at end, shrink, center and end alignment, negative vertical offset
        configure(5'b00111, 16'd0, 16'd10, 16'd1, tbm_pkg::ALIGN_CENTER, tbm_pkg::ALIGN_END,
                  16'h0180, 16'h0100);
        txt = "a<br>b<bx<b\n<<br>~<b";
        foreach (txt[i]) send(mk(tbm_pkg::CMD_TEXT, txt[i]));
        send(mk(tbm_pkg::CMD_END, 0));
        send(mk(tbm_pkg::CMD_TEXT, 8'h7E)); send(mk(tbm_pkg::CMD_TEXT, 8'h20));
        send(mk(tbm_pkg::CMD_END, 0));
        // premeasured extremes and limit, separate advance, zero lines
        configure(5'b11000, 16'd3, 16'hFFFF, 16'hFFFF, tbm_pkg::ALIGN_END, tbm_pkg::ALIGN_CENTER,
                  16'hFFFF, 16'hFFFF);
        send(mk(tbm_pkg::CMD_END, 0, 16'hFFFF, 16'd3));
        send(mk(tbm_pkg::CMD_END, 0, 16'd0, 16'd0));
        send(mk(tbm_pkg::CMD_END, 0, 16'd5, 16'd4));
        send(mk(tbm_pkg::CMD_TEXT, 8'h00)); send(mk(tbm_pkg::CMD_END, 0, 16'd1, 16'd1));
        configure(5'b11001, 16'd0, 16'd1, 16'd1, tbm_pkg::ALIGN_BAD, tbm_pkg::ALIGN_START,
                  16'd1, 16'd0);
        send(mk(tbm_pkg::CMD_END, 0, 16'd1, 16'd1));
        configure(5'b11001, 16'd0, 16'd1, 16'd1, tbm_pkg::ALIGN_START, tbm_pkg::ALIGN_BAD,
                  16'd1, 16'd0);
        send(mk(tbm_pkg::CMD_END, 0, 16'hFFFF, 16'hFFFF));
        settle(); // sender holds until everything has drained
        it = mk(CMD_UNUSED, 8'h41); send(it);

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            configure(5'($urandom), (ph == 0) ? 16'hFFFF : 16'($urandom_range(6)),
                      (ph == 1) ? 16'd1 : 16'($urandom_range(400, 1)),
                      (ph == 2) ? 16'hFFFF : 16'($urandom_range(300, 1)),
                      2'($urandom_range(2)), 2'($urandom_range(2)),
                      16'($urandom), 16'($urandom));
            idle_pct = (ph == 3) ? 0 : 18;
            for (int n = 0; n < 52; n++) begin
                int k;
                k = $urandom_range(99);
                if (k < 4) begin
                    it = mk(tbm_pkg::CMD_LOAD, 0); it.idx = 7'($urandom_range(94));
                end else if (k < 10) begin
                    it = mk(tbm_pkg::CMD_END, 0, 16'($urandom), 16'($urandom_range(8)));
                end else it = mk(tbm_pkg::CMD_TEXT, rand_text());
                send(it);
            end
            send(mk(tbm_pkg::CMD_END, 0, 16'($urandom), 16'($urandom)));
        end
        idle_pct = 18;

        settle();
        if (errors == 0 && layout_q.size() == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/tbm_pkg.sv
design/tbm_width_mem.sv
design/tbm_measure.sv
design/tbm_divider.sv
design/tbm_layout.sv
design/text_block_measure_layout_core.sv
verif/tb_top.sv
